// ===== rtl/ps2ms_pkg.sv =====
// Package for the PS/2 mouse host sequencer: beat types, codes and frame helper.
package ps2ms_pkg;

	// input actions
	localparam logic [1:0] ACT_POLL    = 2'd0;
	localparam logic [1:0] ACT_BYTE    = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;
	// unused code, dropped in every state
	localparam logic [1:0] ACT_SPARE   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_READY  = 2'd2;
	localparam logic [1:0] KIND_DISC   = 2'd3;

	// device bytes and commands
	localparam logic [7:0] ACK_BYTE   = 8'hFA;
	localparam logic [7:0] CMD_ENABLE = 8'hF4;
	localparam logic [7:0] CMD_REMOTE = 8'hF0;
	localparam logic [7:0] CMD_RATE   = 8'hF3;
	localparam logic [7:0] CMD_GET_ID = 8'hF2;
	localparam logic [7:0] CMD_READ   = 8'hEB;
	localparam logic [7:0] RATE_1     = 8'd200;
	localparam logic [7:0] RATE_2     = 8'd100;
	localparam logic [7:0] RATE_3     = 8'd80;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_ACK_EN  = 4'd1,
		ST_ACK_REM = 4'd2,
		ST_ACK_R1  = 4'd3,
		ST_PAR_R1  = 4'd4,
		ST_ACK_R2  = 4'd5,
		ST_PAR_R2  = 4'd6,
		ST_ACK_R3  = 4'd7,
		ST_PAR_R3  = 4'd8,
		ST_ACK_ID  = 4'd9,
		ST_ID_BYTE = 4'd10,
		ST_ACK_RD  = 4'd11,
		ST_PACKET  = 4'd12
	} step_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
	} ev_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [9:0]        frame;
		logic [2:0]        buttons;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic [7:0]        wheel_byte;
		logic [7:0]        device_type;
		logic              last;
	} res_t;

	// start bit low, command byte, odd parity on top
	function automatic res_t send_frame(input logic [7:0] cmd);
		res_t r;
		r = '0;
		r.kind = KIND_FRAME;
		r.frame = {~(^cmd), cmd, 1'b0};
		r.last = 1'b1;
		return r;
	endfunction

endpackage

// ===== rtl/ps2_mouse_host_sequencer.sv =====
// PS/2 mouse host sequencer: init script, packet collection and result queue.
// One event beat is accepted per cycle; it is registered, decoded against the
// sequencer state combinationally and its zero, one or two results go into a
// four-entry result queue. Events are taken whenever the queue has room for two
// results, so the sustained rate is one event per cycle while the result side
// keeps up; a ready event yields two results at the output (device ready plus
// the first read frame). An event passes the input stage, then the result queue.
module ps2_mouse_host_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_valid,
	output logic              ev_ready,
	input  ps2ms_pkg::ev_t    ev_data,
	output logic              res_valid,
	input  logic              res_ready,
	output ps2ms_pkg::res_t   res_data
);

	localparam int DEPTH = 4;

	// input stage
	logic              valid_s1;
	ps2ms_pkg::ev_t    ev_s1;
	logic              adv;

	// sequencer state
	ps2ms_pkg::step_t  step_q, step_d;
	logic              link_q, link_d;
	logic [2:0]        idx_q, idx_d;
	logic [7:0]        type_q, type_d;
	logic [7:0]        pst_q, pst_d;
	logic [7:0]        px_q, px_d;
	logic [7:0]        py_q, py_d;
	logic [7:0]        pw_q, pw_d;

	// results of the current beat
	logic [1:0]        nres;
	ps2ms_pkg::res_t   r0, r1;

	// result queue
	ps2ms_pkg::res_t   fifo_q [DEPTH];
	logic [1:0]        wr_q, rd_q;
	logic [2:0]        cnt_q;
	logic              pop;
	logic              room;

	assign pop = res_valid && res_ready;
	assign room = (cnt_q <= 3'd2) || (pop && cnt_q == 3'd3);
	assign adv = valid_s1 && room;
	assign ev_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ev_ready) begin
			valid_s1 <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && ev_ready) begin
			ev_s1 <= ev_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ps2ms_pkg::ST_IDLE;
			link_q <= 1'b0;
			idx_q  <= 3'd0;
			type_q <= 8'd0;
			pst_q  <= 8'd0;
			px_q   <= 8'd0;
			py_q   <= 8'd0;
			pw_q   <= 8'd0;
		end else if (adv) begin
			step_q <= step_d;
			link_q <= link_d;
			idx_q  <= idx_d;
			type_q <= type_d;
			pst_q  <= pst_d;
			px_q   <= px_d;
			py_q   <= py_d;
			pw_q   <= pw_d;
		end
	end

	always_comb begin
		logic       got;
		logic       ok;
		logic [7:0] b;
		logic [2:0] nidx;
		logic [2:0] plen;
		b      = ev_s1.rx_byte;
		got    = (ev_s1.action == ps2ms_pkg::ACT_BYTE);
		ok     = got && (b == ps2ms_pkg::ACK_BYTE);
		nidx   = idx_q + 3'd1;
		plen   = (type_q == 8'd0) ? 3'd3 : 3'd4;
		step_d = step_q;
		link_d = link_q;
		idx_d  = idx_q;
		type_d = type_q;
		pst_d  = pst_q;
		px_d   = px_q;
		py_d   = py_q;
		pw_d   = pw_q;
		nres   = 2'd0;
		r0     = '0;
		r1     = '0;
		if (ev_s1.action == ps2ms_pkg::ACT_POLL) begin
			if (step_q == ps2ms_pkg::ST_IDLE) begin
				nres = 2'd1;
				if (link_q) begin
					step_d = ps2ms_pkg::ST_ACK_RD;
					r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_READ);
				end else begin
					step_d = ps2ms_pkg::ST_ACK_EN;
					r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_ENABLE);
				end
			end
		end else if (ev_s1.action != ps2ms_pkg::ACT_SPARE &&
		             step_q != ps2ms_pkg::ST_IDLE) begin
			unique case (step_q)
				ps2ms_pkg::ST_ACK_EN: begin
					if (ok) begin
						step_d = ps2ms_pkg::ST_ACK_REM;
						nres = 2'd1;
						r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_REMOTE);
					end else begin
						step_d = ps2ms_pkg::ST_IDLE;
					end
				end
				ps2ms_pkg::ST_ACK_REM: begin
					if (ok) begin
						step_d = ps2ms_pkg::ST_ACK_R1;
						nres = 2'd1;
						r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_RATE);
					end else begin
						step_d = ps2ms_pkg::ST_IDLE;
					end
				end
				ps2ms_pkg::ST_ACK_R1: begin
					nres = 2'd1;
					if (ok) begin
						step_d = ps2ms_pkg::ST_PAR_R1;
						r0 = ps2ms_pkg::send_frame(ps2ms_pkg::RATE_1);
					end else begin
						step_d = ps2ms_pkg::ST_ACK_R2;
						r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_RATE);
					end
				end
				ps2ms_pkg::ST_PAR_R1: begin
					step_d = ps2ms_pkg::ST_ACK_R2;
					nres = 2'd1;
					r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_RATE);
				end
				ps2ms_pkg::ST_ACK_R2: begin
					nres = 2'd1;
					if (ok) begin
						step_d = ps2ms_pkg::ST_PAR_R2;
						r0 = ps2ms_pkg::send_frame(ps2ms_pkg::RATE_2);
					end else begin
						step_d = ps2ms_pkg::ST_ACK_R3;
						r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_RATE);
					end
				end
				ps2ms_pkg::ST_PAR_R2: begin
					step_d = ps2ms_pkg::ST_ACK_R3;
					nres = 2'd1;
					r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_RATE);
				end
				ps2ms_pkg::ST_ACK_R3: begin
					nres = 2'd1;
					if (ok) begin
						step_d = ps2ms_pkg::ST_PAR_R3;
						r0 = ps2ms_pkg::send_frame(ps2ms_pkg::RATE_3);
					end else begin
						step_d = ps2ms_pkg::ST_ACK_ID;
						r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_GET_ID);
					end
				end
				ps2ms_pkg::ST_PAR_R3: begin
					step_d = ps2ms_pkg::ST_ACK_ID;
					nres = 2'd1;
					r0 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_GET_ID);
				end
				ps2ms_pkg::ST_ACK_ID: begin
					step_d = ok ? ps2ms_pkg::ST_ID_BYTE : ps2ms_pkg::ST_IDLE;
				end
				ps2ms_pkg::ST_ID_BYTE: begin
					// a timeout here means a basic mouse
					type_d = got ? b : 8'd0;
					link_d = 1'b1;
					step_d = ps2ms_pkg::ST_ACK_RD;
					nres = 2'd2;
					r0.kind = ps2ms_pkg::KIND_READY;
					r0.device_type = type_d;
					r1 = ps2ms_pkg::send_frame(ps2ms_pkg::CMD_READ);
				end
				ps2ms_pkg::ST_ACK_RD: begin
					if (!got || b == 8'd0) begin
						link_d = 1'b0;
						step_d = ps2ms_pkg::ST_IDLE;
						nres = 2'd1;
						r0.kind = ps2ms_pkg::KIND_DISC;
						r0.last = 1'b1;
					end else begin
						idx_d = 3'd0;
						pw_d = 8'd0;
						step_d = ps2ms_pkg::ST_PACKET;
					end
				end
				ps2ms_pkg::ST_PACKET: begin
					if (!got) begin
						// drop the partial packet
						step_d = ps2ms_pkg::ST_IDLE;
						idx_d = 3'd0;
					end else begin
						case (idx_q[1:0])
							2'd0:    pst_d = b;
							2'd1:    px_d = b;
							2'd2:    py_d = b;
							default: pw_d = b;
						endcase
						idx_d = nidx;
						if (nidx >= plen) begin
							step_d = ps2ms_pkg::ST_IDLE;
							idx_d = 3'd0;
							if ((pst_d[2:0] != 3'd0) || (px_d != 8'd0) ||
							    (py_d != 8'd0) || (pw_d != 8'd0)) begin
								nres = 2'd1;
								r0.kind = ps2ms_pkg::KIND_REPORT;
								r0.buttons = pst_d[2:0];
								r0.move_x = px_d;
								r0.move_y = py_d;
								r0.wheel_byte = pw_d;
								r0.last = 1'b1;
							end
						end
					end
				end
				default: begin
					step_d = ps2ms_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + (adv ? nres : 2'd0);
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, (adv ? nres : 2'd0)} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && nres != 2'd0) begin
			fifo_q[wr_q] <= r0;
		end
		if (adv && nres == 2'd2) begin
			fifo_q[wr_q + 2'd1] <= r1;
		end
	end

	assign res_valid = (cnt_q != 3'd0);
	assign res_data  = fifo_q[rd_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(DEPTH))
		else $error("result queue overfilled");

	a_ready_from_id: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(link_q) |-> $past(step_q) == ps2ms_pkg::ST_ID_BYTE)
		else $error("link came up outside the ID step");

	a_read_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ps2ms_pkg::ST_ACK_RD || step_q == ps2ms_pkg::ST_PACKET) |-> link_q)
		else $error("read sequence while offline");

	a_stage_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && ev_ready) |=> valid_s1)
		else $error("accepted beat lost at input stage");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> ({1'b0, cnt_q} + {2'b0, nres} - {3'b0, pop}) <= 4'(DEPTH))
		else $error("push into full result queue");

endmodule
